// ----- rtl/vrds_pkg.sv -----
// vrds_pkg: shared types and constants of the vertex round/delta/shuffle unit
// no dependencies
`default_nettype none
package vrds_pkg;

    localparam int WordW      = 32;
    localparam int HoldDepth  = 8;
    localparam int GroupWords = 4;
    localparam int QueueDepth = 4;
    localparam int CfgIdxW    = 2;

    // register indexes of the config port
    localparam logic [CfgIdxW-1:0] RegScale   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegStrided = 2'd1;
    localparam logic [CfgIdxW-1:0] RegRound   = 2'd2;

    localparam logic [WordW-1:0] ScaleReset = 32'h3F80_0000;
    localparam logic [WordW-1:0] IntInvalid = 32'h8000_0000;

    // byte order of one transposed group of four words
    localparam logic [3:0] ShuffleOrder [16] = '{
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    typedef struct packed {
        logic [WordW-1:0] value_bits;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [WordW-1:0] out_word;
        logic             out_last;
    } t_out;

    // rounded element on its way from front to back
    typedef struct packed {
        logic [WordW-1:0] value;
        logic             last;
    } t_elem;

endpackage
`default_nettype wire

// ----- rtl/vrds_front.sv -----
// vrds_front: five-stage float scale and round-to-int32 pipeline; raw words pass through when rounding is off
// depends on vrds_pkg
`default_nettype none
module vrds_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire vrds_pkg::t_in               i_item,
    input  wire logic [vrds_pkg::WordW-1:0]  i_scale,
    input  wire logic                        i_round,
    output logic                             o_push,
    output vrds_pkg::t_elem                  o_elem,
    input  wire logic                        i_full
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: mantissa product
    logic [47:0] r1_m;
    logic [8:0]  r1_xs;
    logic        r1_sign, r1_bad, r1_rnd, r1_last;
    logic [31:0] r1_raw;
    // stage 2: leading zero count
    logic [47:0] r2_m;
    logic [5:0]  r2_lz;
    logic signed [10:0] r2_x;
    logic        r2_sign, r2_bad, r2_rnd, r2_last;
    logic [31:0] r2_raw;
    // stage 3: float32 rounding
    logic [23:0] r3_mant;
    logic signed [10:0] r3_x;
    logic        r3_zero, r3_sign, r3_bad, r3_rnd, r3_last;
    logic [31:0] r3_raw;
    // stage 4: integer magnitude
    logic [31:0] r4_mag;
    logic        r4_ovf, r4_sign, r4_rnd, r4_last;
    logic [31:0] r4_raw;
    // stage 5: result
    vrds_pkg::t_elem r5_elem;

    assign en      = !r_v5 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v5 && !i_full;
    assign o_elem  = r5_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [8:0]  xa, xb;
    always_comb begin
        ea = i_item.value_bits[30:23];
        eb = i_scale[30:23];
        ma = {(ea != 8'd0), i_item.value_bits[22:0]};
        mb = {(eb != 8'd0), i_scale[22:0]};
        xa = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
        xb = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m    <= ma * mb;
            r1_xs   <= xa + xb;
            r1_sign <= i_item.value_bits[31] ^ i_scale[31];
            r1_bad  <= (ea == 8'hFF) || (eb == 8'hFF);
            r1_rnd  <= i_round;
            r1_raw  <= i_item.value_bits;
            r1_last <= i_item.last;
        end
    end

    // stage 2
    logic [5:0] lz;
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r1_m[i]) lz = 6'(47 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_m    <= r1_m;
            r2_lz   <= lz;
            // unbiased exponent of the leading one
            r2_x    <= $signed({2'b00, r1_xs}) - $signed({5'b00000, lz}) - 11'sd253;
            r2_sign <= r1_sign;
            r2_bad  <= r1_bad;
            r2_rnd  <= r1_rnd;
            r2_raw  <= r1_raw;
            r2_last <= r1_last;
        end
    end

    // stage 3
    logic [47:0] nrm;
    logic [24:0] msum;
    logic        up3;
    always_comb begin
        nrm  = r2_m << r2_lz;
        up3  = nrm[23] && ((|nrm[22:0]) || nrm[24]);
        msum = {1'b0, nrm[47:24]} + {24'd0, up3};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mant <= msum[24] ? 24'h80_0000 : msum[23:0];
            r3_x    <= msum[24] ? r2_x + 11'sd1 : r2_x;
            r3_zero <= (r2_m == 48'd0);
            r3_sign <= r2_sign;
            r3_bad  <= r2_bad;
            r3_rnd  <= r2_rnd;
            r3_raw  <= r2_raw;
            r3_last <= r2_last;
        end
    end

    // stage 4
    logic [47:0] ext;
    logic [4:0]  rsh;
    logic [2:0]  lsh;
    logic [31:0] mag;
    logic        ovf, up4;
    always_comb begin
        rsh = 5'd0;
        lsh = 3'd0;
        ext = 48'd0;
        up4 = 1'b0;
        mag = 32'd0;
        ovf = r3_bad || (r3_x >= 11'sd31);
        if (!ovf && !r3_zero && (r3_x >= -11'sd1)) begin
            if (r3_x >= 11'sd23) begin
                lsh = 3'(r3_x - 11'sd23);
                mag = {8'd0, r3_mant} << lsh;
            end else begin
                rsh = 5'(11'sd23 - r3_x);
                ext = {r3_mant, 24'd0} >> rsh;
                up4 = ext[23] && ((|ext[22:0]) || ext[24]);
                mag = {8'd0, ext[47:24]} + {31'd0, up4};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mag  <= mag;
            r4_ovf  <= ovf;
            r4_sign <= r3_sign;
            r4_rnd  <= r3_rnd;
            r4_raw  <= r3_raw;
            r4_last <= r3_last;
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r4_rnd) begin
                r5_elem.value <= r4_raw;
            end else if (r4_ovf) begin
                r5_elem.value <= vrds_pkg::IntInvalid;
            end else begin
                r5_elem.value <= r4_sign ? (32'd0 - r4_mag) : r4_mag;
            end
            r5_elem.last <= r4_last;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vrds_fifo.sv -----
// vrds_fifo: short element queue between front and back
// depends on vrds_pkg
`default_nettype none
module vrds_fifo #(
    parameter int Depth = vrds_pkg::QueueDepth
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire vrds_pkg::t_elem i_elem,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output vrds_pkg::t_elem      o_elem
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    vrds_pkg::t_elem r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_elem  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(do_push) - CntW'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vrds_back.sv -----
// vrds_back: hold buffer, forward differences, byte transpose and word emission
// depends on vrds_pkg
`default_nettype none
module vrds_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire vrds_pkg::t_elem i_elem,
    output logic                 o_pop,
    input  wire logic            i_strided,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output vrds_pkg::t_out       o_word
);

    localparam int HD = vrds_pkg::HoldDepth;

    logic [31:0] r_buf  [HD];
    logic [31:0] r_emit [HD];
    logic [2:0]  r_cnt;
    logic [3:0]  r_en, r_ei;
    logic        r_elast;
    logic        r_ov;
    vrds_pkg::t_out r_ow;

    logic        busy, trig, snap, free;
    logic [3:0]  h;
    logic [31:0] view [HD];
    logic [31:0] enc  [HD];
    logic [31:0] wrd  [HD];
    logic [7:0]  src  [16];
    logic [7:0]  dst  [16];
    logic        load;

    assign busy  = (r_ei != r_en);
    assign trig  = i_elem.last || (r_cnt == 3'(HD - 1));
    // the emit bank may be refilled in the cycle its final word loads
    assign free  = !busy || (load && (r_ei + 4'd1 == r_en));
    assign o_pop = i_valid && (free || !trig);
    assign snap  = o_pop && trig;
    assign h     = {1'b0, r_cnt} + 4'd1;
    assign load  = busy && (!r_ov || i_ready);

    always_comb begin
        for (int i = 0; i < HD; i++) begin
            view[i] = (3'(i) == r_cnt) ? i_elem.value : r_buf[i];
        end
        for (int b = 0; b < HD; b++) begin
            enc[b] = view[b];
            if (i_strided) begin
                if (((b & ~1) + 3 < int'(h)) && (b + 2 < HD)) begin
                    enc[b] = view[(b + 2) % HD] - view[b];
                end
            end else begin
                if ((b + 1 < int'(h)) && (b + 1 < HD)) begin
                    enc[b] = view[(b + 1) % HD] - view[b];
                end
            end
        end
        for (int g = 0; g < 2; g++) begin
            for (int j = 0; j < 16; j++) begin
                src[j] = enc[4 * g + (j >> 2)][8 * (j & 3) +: 8];
            end
            for (int j = 0; j < 16; j++) begin
                dst[j] = src[vrds_pkg::ShuffleOrder[j]];
            end
            for (int k = 0; k < 4; k++) begin
                // only full groups are transposed
                if (int'(h) >= 4 * (g + 1)) begin
                    wrd[4 * g + k] = {dst[4 * k + 3], dst[4 * k + 2],
                                      dst[4 * k + 1], dst[4 * k]};
                end else begin
                    wrd[4 * g + k] = enc[4 * g + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap) begin
            for (int i = 0; i < HD; i++) begin
                r_emit[i] <= wrd[i];
            end
        end
        if (o_pop) begin
            if (snap && !i_elem.last) begin
                for (int i = 0; i < HD / 2; i++) begin
                    r_buf[i] <= view[i + HD / 2];
                end
            end else if (!snap) begin
                r_buf[r_cnt] <= i_elem.value;
            end
        end
        if (load) begin
            r_ow.out_word <= r_emit[r_ei[2:0]];
            r_ow.out_last <= r_elast && (r_ei + 4'd1 == r_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_en    <= '0;
            r_ei    <= '0;
            r_elast <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_pop) begin
                if (snap) begin
                    r_cnt   <= i_elem.last ? 3'd0 : 3'(HD / 2);
                    r_en    <= i_elem.last ? h : 4'(vrds_pkg::GroupWords);
                    r_ei    <= '0;
                    r_elast <= i_elem.last;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            if (load && !snap) begin
                r_ei <= r_ei + 4'd1;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_ow;

endmodule
`default_nettype wire

// ----- rtl/vertex_round_delta_shuffle_unit.sv -----
// vertex_round_delta_shuffle_unit: top level, config registers and channel wiring
// depends on vrds_pkg, vrds_front, vrds_fifo, vrds_back
//
// channel   signals                               role
// in        i_in_valid / o_in_ready / i_in        one element word, last marks array end
// out       o_out_valid / i_out_ready / o_out     one encoded word
// cfg       i_cfg_valid / o_cfg_ready / index, data  register writes
//
// one element per cycle enters the five-stage rounding pipeline when not stalled and passes
// its stage registers and the queue to the back end. the back end takes one element per cycle
// unless held, and drains one word per cycle from its emit bank while o_out is free or taken;
// a bank still draining holds the back end only at a group boundary or array end, until
// its final word loads; output stalls back up through the queue into the front pipeline.
// reset is synchronous; no clearing pass, input ready as soon as reset is released.
`default_nettype none
module vertex_round_delta_shuffle_unit #(
    parameter int QDepth = vrds_pkg::QueueDepth
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire vrds_pkg::t_in                  i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output vrds_pkg::t_out                      o_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [vrds_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [vrds_pkg::WordW-1:0]     i_cfg_data
);

    logic [vrds_pkg::WordW-1:0] r_scale;
    logic                       r_strided;
    logic                       r_round;

    logic            f_push, q_full, q_valid, q_pop;
    vrds_pkg::t_elem f_elem, q_elem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= vrds_pkg::ScaleReset;
            r_strided <= 1'b1;
            r_round   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vrds_pkg::RegScale:   r_scale   <= i_cfg_data;
                vrds_pkg::RegStrided: r_strided <= i_cfg_data[0];
                vrds_pkg::RegRound:   r_round   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vrds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .i_scale (r_scale),
        .i_round (r_round),
        .o_push  (f_push),
        .o_elem  (f_elem),
        .i_full  (q_full)
    );

    vrds_fifo #(
        .Depth (QDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_elem  (f_elem),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_elem  (q_elem)
    );

    vrds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_elem    (q_elem),
        .o_pop     (q_pop),
        .i_strided (r_strided),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out)
    );

endmodule
`default_nettype wire
